/* sv/ssp_pkg.sv */
// Shared types, constants and helper functions of the stride and stream prefetcher.
package ssp_pkg;

    localparam int IP_ENTRIES     = 64;
    localparam int REGION_ENTRIES = 8;
    localparam int ADDR_BITS      = 48;
    localparam int QUEUE_DEPTH    = 2;

    localparam int IP_IW   = $clog2(IP_ENTRIES);
    localparam int RG_IW   = $clog2(REGION_ENTRIES);
    localparam int SCAN_N  = (IP_ENTRIES > REGION_ENTRIES) ? IP_ENTRIES : REGION_ENTRIES;
    localparam int SCAN_W  = $clog2(SCAN_N);
    localparam int FLD_W   = 48;
    localparam int TAG_W   = 16;

    localparam logic [1:0]  KIND_NONE    = 2'd0;
    localparam logic [1:0]  KIND_STREAM  = 2'd1;
    localparam logic [1:0]  KIND_STRIDE  = 2'd2;
    localparam logic [1:0]  KIND_PATTERN = 2'd3;

    localparam logic        OP_LOAD = 1'b0;
    localparam logic        OP_TICK = 1'b1;

    localparam logic [4:0]  THR_RESET = 5'd12;
    localparam logic [4:0]  IDLE_MAX  = 5'h1F;
    localparam logic [2:0]  AGE_MAX   = 3'd7;
    localparam logic [2:0]  AGE_INS   = 3'd5;
    localparam logic [17:0] DSUM_MAX  = 18'h1FFFF;
    localparam logic [4:0]  PHIST_ALL = 5'h1F;
    localparam logic [4:0]  CNT_MAX   = 5'd16;

    typedef struct packed {
        logic                 tick;
        logic [ADDR_BITS-1:0] addr;
        logic [TAG_W-1:0]     itag;
        logic [TAG_W-1:0]     rtag;
        logic [3:0]           line;
    } t_job;

    typedef struct packed {
        logic [31:0]     last;
        logic [1:0]      conf;
        logic [1:0]      step;
        logic [23:0]     stride;
        logic [4:0][3:0] hist;
        logic [17:0]     dsum;
        logic [4:0]      phist;
        logic [2:0]      plast;
    } t_ipdat;

    function automatic logic [1:0] step_of(input logic [4:0] idle);
        return (idle < 5'd8) ? 2'd2 : ((idle < 5'd16) ? 2'd1 : 2'd0);
    endfunction

    function automatic logic [1:0] step_base(input logic [1:0] st);
        return (st >= 2'd2) ? 2'd3 : ((st == 2'd1) ? 2'd2 : 2'd1);
    endfunction

    function automatic logic [2:0] age_dec(input logic [2:0] age);
        return (age < 3'd2) ? 3'd0 : age - 3'd2;
    endfunction

endpackage

/* sv/ssp_if.sv */
// Channel interfaces for access input, prefetch output and threshold configuration.
interface ssp_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [47:0] access_addr;
    logic [47:0] instr_ptr;
    modport source(output valid, op, access_addr, instr_ptr, input ready);
    modport sink(input valid, op, access_addr, instr_ptr, output ready);
endinterface

interface ssp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  pf_kind;
    logic        pf_valid;
    logic [47:0] pf_near_addr;
    logic [47:0] pf_mid_addr;
    logic [47:0] pf_llc_addr;
    modport source(output valid, pf_kind, pf_valid, pf_near_addr, pf_mid_addr, pf_llc_addr,
                   input ready);
    modport sink(input valid, pf_kind, pf_valid, pf_near_addr, pf_mid_addr, pf_llc_addr,
                 output ready);
endinterface

interface ssp_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

/* sv/ssp_front.sv */
// Front end: accepts transactions and folds them into table lookup keys.
module ssp_front import ssp_pkg::*; (
    ssp_in_if.sink   i_in,
    input  logic     i_full,
    output logic     o_push,
    output t_job     o_job
);
    logic [ADDR_BITS-1:0] addr;

    assign addr        = ADDR_BITS'(i_in.access_addr);
    assign i_in.ready  = !i_full;
    assign o_push      = i_in.valid && !i_full;

    always_comb begin
        o_job.tick = (i_in.op == OP_TICK);
        o_job.addr = addr;
        o_job.itag = i_in.instr_ptr[17:2] ^ i_in.instr_ptr[33:18];
        o_job.rtag = addr[25:10];
        o_job.line = addr[9:6];
    end
endmodule

/* sv/ssp_queue.sv */
// Short queue that decouples the front end from the table engine.
module ssp_queue import ssp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end
endmodule

/* sv/ssp_back.sv */
// Table engine: IP stride and pattern table, region table, victim scan and result register.
module ssp_back import ssp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_job_pop,
    ssp_cfg_if.sink    i_cfg,
    ssp_out_if.source  o_out
);
    localparam logic [1:0] ST_LOOK   = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0] r_state;
    logic [4:0] r_thr;

    logic [IP_ENTRIES-1:0] r_ip_vld;
    logic [TAG_W-1:0]      r_ip_tag  [IP_ENTRIES];
    logic [2:0]            r_ip_age  [IP_ENTRIES];
    logic [4:0]            r_ip_idle [IP_ENTRIES];
    t_ipdat                r_mem     [IP_ENTRIES];
    t_ipdat                r_rd;

    logic [REGION_ENTRIES-1:0] r_rg_vld;
    logic [TAG_W-1:0]          r_rg_tag   [REGION_ENTRIES];
    logic [4:0]                r_rg_cnt   [REGION_ENTRIES];
    logic [15:0]               r_rg_bits  [REGION_ENTRIES];
    logic                      r_rg_dir   [REGION_ENTRIES];
    logic                      r_rg_dense [REGION_ENTRIES];
    logic [2:0]                r_rg_age   [REGION_ENTRIES];
    logic [1:0]                r_rg_step  [REGION_ENTRIES];

    t_job             r_job;
    logic             r_ip_hit, r_ip_free, r_rg_hit, r_rg_free;
    logic [IP_IW-1:0] r_ip_idx;
    logic [RG_IW-1:0] r_rg_idx;
    logic             r_nb_dir, r_nb_dense;
    logic [1:0]       r_nb_step;

    logic                 r_need_ipv, r_need_rgv;
    logic [1:0]           r_kind, r_sb;
    logic [ADDR_BITS-1:0] r_delta;

    logic [SCAN_W-1:0] r_scan;
    logic              r_vip_ok, r_vrg_ok;
    logic [IP_IW-1:0]  r_vip_idx;
    logic [RG_IW-1:0]  r_vrg_idx;
    logic [TAG_W-1:0]  r_vip_tag, r_vrg_tag;

    logic        r_ov, r_opv;
    logic [1:0]  r_okind;
    logic [FLD_W-1:0] r_oa1, r_oa2, r_oa3;

    // Lookup stage.
    logic [IP_ENTRIES-1:0]     lk_ip_match;
    logic [REGION_ENTRIES-1:0] lk_rg_match;
    logic             lk_ip_hit, lk_ip_free, lk_rg_hit, lk_rg_free, lk_up, lk_dn;
    logic [IP_IW-1:0] lk_ip_hidx, lk_ip_fidx;
    logic [RG_IW-1:0] lk_rg_hidx, lk_rg_fidx, lk_up_idx, lk_dn_idx;
    logic             lk_dir, lk_dense;
    logic [1:0]       lk_step;

    always_comb begin
        lk_ip_hit  = 1'b0;
        lk_ip_free = 1'b0;
        lk_ip_hidx = '0;
        lk_ip_fidx = '0;
        for (int i = IP_ENTRIES - 1; i >= 0; i--) begin
            lk_ip_match[i] = r_ip_vld[i] && (r_ip_tag[i] == i_job.itag);
            if (lk_ip_match[i]) begin
                lk_ip_hit  = 1'b1;
                lk_ip_hidx = IP_IW'(i);
            end
            if (!r_ip_vld[i]) begin
                lk_ip_free = 1'b1;
                lk_ip_fidx = IP_IW'(i);
            end
        end
        lk_rg_hit  = 1'b0;
        lk_rg_free = 1'b0;
        lk_up      = 1'b0;
        lk_dn      = 1'b0;
        lk_rg_hidx = '0;
        lk_rg_fidx = '0;
        lk_up_idx  = '0;
        lk_dn_idx  = '0;
        for (int i = REGION_ENTRIES - 1; i >= 0; i--) begin
            lk_rg_match[i] = r_rg_vld[i] && (r_rg_tag[i] == i_job.rtag);
            if (lk_rg_match[i]) begin
                lk_rg_hit  = 1'b1;
                lk_rg_hidx = RG_IW'(i);
            end
            if (!r_rg_vld[i]) begin
                lk_rg_free = 1'b1;
                lk_rg_fidx = RG_IW'(i);
            end
            if (r_rg_vld[i] && i_job.rtag != 16'hFFFF && r_rg_tag[i] == i_job.rtag + 16'd1) begin
                lk_up     = 1'b1;
                lk_up_idx = RG_IW'(i);
            end
            if (r_rg_vld[i] && i_job.rtag != 16'h0 && r_rg_tag[i] == i_job.rtag - 16'd1) begin
                lk_dn     = 1'b1;
                lk_dn_idx = RG_IW'(i);
            end
        end
        lk_dir   = 1'b0;
        lk_dense = 1'b0;
        lk_step  = 2'd0;
        if (lk_up) begin
            lk_dir   = 1'b1;
            lk_dense = r_rg_dense[lk_up_idx];
            lk_step  = r_rg_step[lk_up_idx];
        end
        if (lk_dn) begin
            lk_dir   = 1'b0;
            lk_dense = r_rg_dense[lk_dn_idx];
            lk_step  = r_rg_step[lk_dn_idx];
        end
    end

    assign o_job_pop = (r_state == ST_LOOK) && i_job_valid;

    // Execute stage.
    logic [31:0] s;
    logic [3:0]  ps;
    logic        seq, s_small;
    logic [1:0]  conf_dn;
    logic [2:0]  hidx;
    logic        phit;
    logic [4:0]  phist_n, phist_sh;
    logic [18:0] dsum_sum;
    t_ipdat      upd, ins;
    logic        rg_dense_c, rg_dir_c, rg_new;
    logic [1:0]  rg_step_c;
    logic [4:0]  rg_cnt_n;
    logic [1:0]  ex_kind, ex_sb;
    logic [ADDR_BITS-1:0] ex_delta;

    always_comb begin
        s       = r_job.addr[31:0] - r_rd.last;
        ps      = s[3:0] ^ s[7:4] ^ s[11:8] ^ s[15:12];
        s_small = (s[31:24] == 8'h0);
        seq     = s_small && (s[23:0] == r_rd.stride);
        upd     = r_rd;
        if (seq) begin
            if (r_rd.conf < 2'd3) begin
                upd.conf = r_rd.conf + 2'd1;
            end
        end else begin
            conf_dn  = (r_rd.conf > 2'd1) ? r_rd.conf - 2'd1 : r_rd.conf;
            upd.conf = conf_dn;
            if (conf_dn == 2'd1) begin
                upd.stride = s_small ? s[23:0] : 24'h0;
            end
        end
        conf_dn = (r_rd.conf > 2'd1) ? r_rd.conf - 2'd1 : r_rd.conf;
        hidx = 3'd0;
        for (int i = 4; i >= 0; i--) begin
            if (r_rd.hist[i] == ps) begin
                hidx = 3'(i + 1);
            end
        end
        phit      = (hidx != 3'd0) && (r_rd.plast == hidx);
        phist_n   = {r_rd.phist[3:0], phit};
        phist_sh  = phist_n >> hidx;
        upd.phist = phist_n;
        upd.plast = hidx;
        upd.hist  = {r_rd.hist[3:0], ps};
        dsum_sum  = {1'b0, r_rd.dsum} + 19'(s[7:0]);
        if (!phit) begin
            upd.dsum = 18'h0;
        end else if (hidx == 3'd5 || !phist_sh[0]) begin
            if (s[31:8] == 24'h0) begin
                upd.dsum = (dsum_sum > 19'(DSUM_MAX)) ? DSUM_MAX : dsum_sum[17:0];
            end else begin
                upd.dsum  = 18'h0;
                upd.phist = 5'h0;
                upd.plast = 3'd0;
            end
        end
        upd.step = step_of(r_ip_idle[r_ip_idx]);
        upd.last = r_job.addr[31:0];

        ins        = '0;
        ins.conf   = 2'd1;
        ins.last   = r_job.addr[31:0];

        rg_dense_c = r_rg_hit ? r_rg_dense[r_rg_idx] : r_nb_dense;
        rg_dir_c   = r_rg_hit ? r_rg_dir[r_rg_idx] : r_nb_dir;
        rg_step_c  = r_rg_hit ? r_rg_step[r_rg_idx] : r_nb_step;
        rg_new     = !r_rg_bits[r_rg_idx][r_job.line];
        rg_cnt_n   = (r_rg_cnt[r_rg_idx] < CNT_MAX) ? r_rg_cnt[r_rg_idx] + 5'd1
                                                    : r_rg_cnt[r_rg_idx];

        ex_kind  = KIND_NONE;
        ex_sb    = 2'd0;
        ex_delta = '0;
        if (r_ip_hit && r_rd.phist == PHIST_ALL) begin
            ex_kind  = KIND_PATTERN;
            ex_delta = ADDR_BITS'(r_rd.dsum);
        end
        if (r_ip_hit && (r_rd.conf == 2'd3 || (r_rd.conf == 2'd2 && seq))) begin
            ex_kind  = KIND_STRIDE;
            ex_sb    = step_base(r_rd.step);
            ex_delta = {{(ADDR_BITS-24){r_rd.stride[23]}}, r_rd.stride};
        end
        if (rg_dense_c) begin
            ex_kind  = KIND_STREAM;
            ex_sb    = step_base(rg_step_c);
            ex_delta = rg_dir_c ? ('0 - ADDR_BITS'(64)) : ADDR_BITS'(64);
        end
    end

    // Commit stage.
    logic                 out_free;
    logic [ADDR_BITS-1:0] cm_a1, cm_a2, cm_a3;

    assign out_free = !r_ov || o_out.ready;

    always_comb begin
        cm_a1 = r_job.addr + (r_delta << r_sb);
        cm_a2 = r_job.addr + (r_delta << (3'(r_sb) + 3'd1));
        cm_a3 = r_job.addr + (r_delta << (3'(r_sb) + 3'd3));
        if (r_kind == KIND_NONE) begin
            cm_a1 = '0;
            cm_a2 = '0;
            cm_a3 = '0;
        end
    end

    // Victim scan reads one entry of each table per cycle while the index lies within that table.
    logic [IP_IW-1:0] sc_ip;
    logic [RG_IW-1:0] sc_rg;
    logic             sc_ip_in, sc_rg_in;

    assign sc_ip    = IP_IW'(r_scan);
    assign sc_rg    = RG_IW'(r_scan);
    assign sc_ip_in = (32'(r_scan) < IP_ENTRIES);
    assign sc_rg_in = (32'(r_scan) < REGION_ENTRIES);

    // IP payload memory.
    logic             mem_we;
    logic [IP_IW-1:0] mem_wa;
    t_ipdat           mem_wd;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_ip_idx;
        mem_wd = r_ip_hit ? upd : ins;
        if (r_state == ST_EXEC && (r_ip_hit || r_ip_free)) begin
            mem_we = 1'b1;
        end else if (r_state == ST_COMMIT && out_free && r_need_ipv && r_vip_ok) begin
            mem_we = 1'b1;
            mem_wa = r_vip_idx;
            mem_wd = ins;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (o_job_pop) begin
            r_rd <= r_mem[lk_ip_hidx];
        end
    end

    assign i_cfg.ready = 1'b1;

    // Control and pipeline registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOOK;
            r_thr   <= THR_RESET;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_thr <= i_cfg.data;
            end
            if (r_state == ST_COMMIT && out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_LOOK: begin
                    if (i_job_valid && !i_job.tick) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if ((!r_ip_hit && !r_ip_free) || (!r_rg_hit && !r_rg_free)) begin
                        r_state <= ST_SCAN;
                    end else begin
                        r_state <= ST_COMMIT;
                    end
                end
                ST_SCAN: begin
                    if (r_scan == SCAN_W'(SCAN_N - 1)) begin
                        r_state <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    if (out_free) begin
                        r_state <= ST_LOOK;
                    end
                end
                default: begin
                    r_state <= ST_LOOK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job      <= i_job;
            r_ip_hit   <= lk_ip_hit;
            r_ip_free  <= lk_ip_free;
            r_ip_idx   <= lk_ip_hit ? lk_ip_hidx : lk_ip_fidx;
            r_rg_hit   <= lk_rg_hit;
            r_rg_free  <= lk_rg_free;
            r_rg_idx   <= lk_rg_hit ? lk_rg_hidx : lk_rg_fidx;
            r_nb_dir   <= lk_dir;
            r_nb_dense <= lk_dense;
            r_nb_step  <= lk_step;
        end
        if (r_state == ST_EXEC) begin
            r_need_ipv <= !r_ip_hit && !r_ip_free;
            r_need_rgv <= !r_rg_hit && !r_rg_free;
            r_kind     <= ex_kind;
            r_sb       <= ex_sb;
            r_delta    <= ex_delta;
            r_scan     <= '0;
            r_vip_ok   <= 1'b0;
            r_vrg_ok   <= 1'b0;
        end
        if (r_state == ST_SCAN) begin
            r_scan <= r_scan + 1'b1;
            if (sc_ip_in && r_ip_age[sc_ip] == AGE_MAX &&
                (!r_vip_ok || r_ip_tag[sc_ip] < r_vip_tag)) begin
                r_vip_ok  <= 1'b1;
                r_vip_idx <= sc_ip;
                r_vip_tag <= r_ip_tag[sc_ip];
            end
            if (sc_rg_in && r_rg_age[sc_rg] == AGE_MAX &&
                (!r_vrg_ok || r_rg_tag[sc_rg] < r_vrg_tag)) begin
                r_vrg_ok  <= 1'b1;
                r_vrg_idx <= sc_rg;
                r_vrg_tag <= r_rg_tag[sc_rg];
            end
        end
        if (r_state == ST_COMMIT && out_free) begin
            r_okind <= r_kind;
            r_opv   <= (cm_a1 != '0);
            r_oa1   <= FLD_W'(cm_a1);
            r_oa2   <= FLD_W'(cm_a2);
            r_oa3   <= FLD_W'(cm_a3);
        end
    end

    // Table entries.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip_vld <= '0;
            r_rg_vld <= '0;
        end else begin
            if (o_job_pop && i_job.tick) begin
                for (int i = 0; i < IP_ENTRIES; i++) begin
                    if (r_ip_vld[i] && r_ip_idle[i] != IDLE_MAX) begin
                        r_ip_idle[i] <= r_ip_idle[i] + 5'd1;
                    end
                end
            end
            if (r_state == ST_EXEC) begin
                if (r_ip_hit) begin
                    r_ip_idle[r_ip_idx] <= 5'd0;
                    r_ip_age[r_ip_idx]  <= age_dec(r_ip_age[r_ip_idx]);
                end else if (r_ip_free) begin
                    r_ip_vld[r_ip_idx]  <= 1'b1;
                    r_ip_tag[r_ip_idx]  <= r_job.itag;
                    r_ip_age[r_ip_idx]  <= AGE_INS;
                    r_ip_idle[r_ip_idx] <= 5'd0;
                end
                if (r_rg_hit) begin
                    if (rg_new) begin
                        r_rg_cnt[r_rg_idx] <= rg_cnt_n;
                        if (rg_cnt_n >= r_thr) begin
                            r_rg_dense[r_rg_idx] <= 1'b1;
                        end
                    end
                    r_rg_bits[r_rg_idx][r_job.line] <= 1'b1;
                    r_rg_step[r_rg_idx] <= 2'd2;
                    r_rg_age[r_rg_idx]  <= age_dec(r_rg_age[r_rg_idx]);
                end else if (r_rg_free) begin
                    r_rg_vld[r_rg_idx]   <= 1'b1;
                    r_rg_tag[r_rg_idx]   <= r_job.rtag;
                    r_rg_cnt[r_rg_idx]   <= 5'd1;
                    r_rg_bits[r_rg_idx]  <= 16'(1) << r_job.line;
                    r_rg_dir[r_rg_idx]   <= r_nb_dir;
                    r_rg_dense[r_rg_idx] <= r_nb_dense;
                    r_rg_age[r_rg_idx]   <= AGE_INS;
                    r_rg_step[r_rg_idx]  <= r_nb_step;
                end
            end
            if (r_state == ST_COMMIT && out_free) begin
                if (r_need_ipv) begin
                    if (r_vip_ok) begin
                        r_ip_tag[r_vip_idx]  <= r_job.itag;
                        r_ip_age[r_vip_idx]  <= AGE_INS;
                        r_ip_idle[r_vip_idx] <= 5'd0;
                    end else begin
                        for (int i = 0; i < IP_ENTRIES; i++) begin
                            if (r_ip_age[i] != AGE_MAX) begin
                                r_ip_age[i] <= r_ip_age[i] + 3'd1;
                            end
                        end
                    end
                end
                if (r_need_rgv) begin
                    if (r_vrg_ok) begin
                        r_rg_tag[r_vrg_idx]   <= r_job.rtag;
                        r_rg_cnt[r_vrg_idx]   <= 5'd1;
                        r_rg_bits[r_vrg_idx]  <= 16'(1) << r_job.line;
                        r_rg_dir[r_vrg_idx]   <= r_nb_dir;
                        r_rg_dense[r_vrg_idx] <= r_nb_dense;
                        r_rg_age[r_vrg_idx]   <= AGE_INS;
                        r_rg_step[r_vrg_idx]  <= r_nb_step;
                    end else begin
                        for (int i = 0; i < REGION_ENTRIES; i++) begin
                            if (r_rg_age[i] != AGE_MAX) begin
                                r_rg_age[i] <= r_rg_age[i] + 3'd1;
                            end
                        end
                    end
                end
            end
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.pf_kind      = r_okind;
    assign o_out.pf_valid     = r_opv;
    assign o_out.pf_near_addr = r_oa1;
    assign o_out.pf_mid_addr  = r_oa2;
    assign o_out.pf_llc_addr  = r_oa3;

    a_ip_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOK && i_job_valid) |-> $onehot0(lk_ip_match))
        else $error("IP table holds a duplicate tag");
    a_rg_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOK && i_job_valid) |-> $onehot0(lk_rg_match))
        else $error("Region table holds a duplicate tag");
    a_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_job_pop && !i_job.tick) |=> (r_state == ST_EXEC))
        else $error("Load access did not enter execution");
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_okind == KIND_NONE) |-> !r_opv)
        else $error("Result without a prefetch kind is marked valid");
    a_victim_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state == ST_COMMIT) |-> (r_need_ipv && r_vip_ok))
        else $error("Unexpected IP table write during commit");
endmodule

/* sv/stride_stream_pattern_prefetcher.sv */
// Top level of the stride, pattern and region stream prefetcher.
//
//  Port    Dir  Transaction
//  i_in    in   op, access_addr, instr_ptr: a load access or a tick
//  o_out   out  pf_kind, pf_valid, pf_near_addr, pf_mid_addr, pf_llc_addr
//  i_cfg   in   data: dense_threshold
//
// A tick is handled in the lookup state of the table engine and gives no result.
// A load access goes through lookup, execute and commit; when a table is full and misses, a
// victim scan over every IP table entry, one per cycle, runs between execute and commit.
// Reset invalidates both tables at once and sets the threshold to 12; there is no clearing pass.
// The two-entry queue accepts input until full while the result register waits on o_out.ready.
module stride_stream_pattern_prefetcher import ssp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssp_in_if.sink    i_in,
    ssp_cfg_if.sink   i_cfg,
    ssp_out_if.source o_out
);
    logic push, full, pop, q_valid;
    t_job f_job, q_job;

    ssp_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_job  (f_job)
    );

    ssp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    ssp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_pop   (pop),
        .i_cfg       (i_cfg),
        .o_out       (o_out)
    );
endmodule

/* sim/tb.sv */
// Self-checking testbench of the stride, pattern and region stream prefetcher.
module tb;
    import ssp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit        valid;
        bit [15:0] tag;
        bit [31:0] last;
        bit [1:0]  conf;
        bit [2:0]  age;
        bit [4:0]  idle;
        bit [1:0]  step;
        bit [23:0] stride;
        bit [3:0]  hist [5];
        bit [17:0] dsum;
        bit [4:0]  phist;
        bit [2:0]  plast;
    } t_ip_line;

    typedef struct {
        bit        valid;
        bit [15:0] tag;
        bit [4:0]  cnt;
        bit [15:0] bits;
        bit        dir;
        bit        dense;
        bit [2:0]  age;
        bit [1:0]  step;
    } t_region_line;

    typedef struct {
        bit [1:0]  kind;
        bit        pf_valid;
        bit [47:0] l1;
        bit [47:0] l2;
        bit [47:0] llc;
    } t_prefetch;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ssp_in_if  in_ch();
    ssp_out_if out_ch();
    ssp_cfg_if cfg_ch();

    stride_stream_pattern_prefetcher DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .i_cfg  (cfg_ch.sink),
        .o_out  (out_ch.source)
    );

    t_ip_line     ip_tab [IP_ENTRIES];
    t_region_line rg_tab [REGION_ENTRIES];
    bit [4:0]     dense_thr;
    t_prefetch    pf_expect_q[$];
    int           err_count = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;

    bit [47:0]    pool_ip   [12];
    bit [47:0]    pool_addr [12];
    bit [31:0]    pool_pat  [12][5];
    int           pool_per  [12];
    int           pool_pos  [12];
    bit [47:0]    sweep_addr;

    always #6 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic bit [47:0] rand48();
        return {16'($urandom_range(16'hFFFF, 0)), $urandom()};
    endfunction

    function automatic bit [47:0] scale_addr(bit [47:0] base, bit [63:0] delta, bit [1:0] st,
                                             int radix);
        int sh;
        sh = ((st >= 2) ? 3 : ((st == 1) ? 2 : 1)) + radix;
        return base + 48'(delta << sh);
    endfunction

    function automatic int lookup_region(bit [15:0] tag);
        for (int i = 0; i < REGION_ENTRIES; i++)
            if (rg_tab[i].valid && rg_tab[i].tag == tag) return i;
        return -1;
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < IP_ENTRIES; i++) ip_tab[i] = '{default: '0};
        for (int i = 0; i < REGION_ENTRIES; i++) rg_tab[i] = '{default: '0};
        dense_thr = THR_RESET;
    endfunction

    function automatic void tick_model();
        for (int i = 0; i < IP_ENTRIES; i++)
            if (ip_tab[i].valid && ip_tab[i].idle < IDLE_MAX) ip_tab[i].idle++;
    endfunction

    function automatic t_prefetch predict_access(bit [47:0] addr, bit [47:0] ip);
        t_prefetch r;
        bit [15:0] itag;
        bit [31:0] s;
        bit [3:0]  ps;
        bit [63:0] d;
        bit [18:0] sum;
        bit [15:0] rtag, lmask;
        bit        phit, ndense, ndir;
        bit [1:0]  nstep;
        int        hit, slot, hidx, n;
        r = '{default: '0};
        hit = -1;
        slot = -1;
        itag = ip[17:2] ^ ip[33:18];
        for (int i = 0; i < IP_ENTRIES; i++)
            if (ip_tab[i].valid && ip_tab[i].tag == itag) begin
                hit = i;
                break;
            end
        if (hit >= 0) begin
            s = addr[31:0] - ip_tab[hit].last;
            ps = s[3:0] ^ s[7:4] ^ s[11:8] ^ s[15:12];
            hidx = 0;
            if (ip_tab[hit].phist == PHIST_ALL) begin
                r.l1 = addr + 48'(ip_tab[hit].dsum);
                r.l2 = addr + (48'(ip_tab[hit].dsum) << 1);
                r.llc = addr + (48'(ip_tab[hit].dsum) << 3);
                r.kind = KIND_PATTERN;
            end
            if (ip_tab[hit].conf == 3 ||
                (ip_tab[hit].conf == 2 && {8'd0, ip_tab[hit].stride} == s)) begin
                d = {{40{ip_tab[hit].stride[23]}}, ip_tab[hit].stride};
                r.l1 = scale_addr(addr, d, ip_tab[hit].step, 0);
                r.l2 = scale_addr(addr, d, ip_tab[hit].step, 1);
                r.llc = scale_addr(addr, d, ip_tab[hit].step, 3);
                r.kind = KIND_STRIDE;
            end
            if ({8'd0, ip_tab[hit].stride} == s) begin
                if (ip_tab[hit].conf < 3) ip_tab[hit].conf++;
            end else begin
                if (ip_tab[hit].conf > 1) ip_tab[hit].conf--;
                if (ip_tab[hit].conf == 1)
                    ip_tab[hit].stride = (s[31:24] == 0) ? s[23:0] : 24'd0;
            end
            for (int i = 0; i < 5; i++)
                if (ip_tab[hit].hist[i] == ps) begin
                    hidx = i + 1;
                    break;
                end
            phit = hidx != 0 && ip_tab[hit].plast == hidx;
            ip_tab[hit].phist = {ip_tab[hit].phist[3:0], phit};
            ip_tab[hit].plast = 3'(hidx);
            for (int i = 4; i > 0; i--) ip_tab[hit].hist[i] = ip_tab[hit].hist[i-1];
            ip_tab[hit].hist[0] = ps;
            if (!phit) begin
                ip_tab[hit].dsum = 0;
            end else if (hidx == 5 || ip_tab[hit].phist[hidx] == 1'b0) begin
                if (s[31:8] == 0) begin
                    sum = 19'(ip_tab[hit].dsum) + 19'(s[7:0]);
                    ip_tab[hit].dsum = (sum > 19'(DSUM_MAX)) ? DSUM_MAX : sum[17:0];
                end else begin
                    ip_tab[hit].dsum = 0;
                    ip_tab[hit].phist = 0;
                    ip_tab[hit].plast = 0;
                end
            end
            ip_tab[hit].step = (ip_tab[hit].idle < 8) ? 2'd2 :
                               ((ip_tab[hit].idle < 16) ? 2'd1 : 2'd0);
            ip_tab[hit].last = addr[31:0];
            ip_tab[hit].idle = 0;
            ip_tab[hit].age = (ip_tab[hit].age < 2) ? 3'd0 : ip_tab[hit].age - 3'd2;
        end else begin
            for (int i = 0; i < IP_ENTRIES; i++)
                if (!ip_tab[i].valid) begin
                    slot = i;
                    break;
                end
            if (slot < 0)
                for (int i = 0; i < IP_ENTRIES; i++)
                    if (ip_tab[i].age == AGE_MAX &&
                        (slot < 0 || ip_tab[i].tag < ip_tab[slot].tag)) slot = i;
            if (slot >= 0) begin
                ip_tab[slot] = '{default: '0};
                ip_tab[slot].valid = 1'b1;
                ip_tab[slot].tag = itag;
                ip_tab[slot].conf = 1;
                ip_tab[slot].last = addr[31:0];
                ip_tab[slot].age = AGE_INS;
            end else begin
                for (int i = 0; i < IP_ENTRIES; i++)
                    if (ip_tab[i].age < AGE_MAX) ip_tab[i].age++;
            end
        end

        rtag = addr[25:10];
        lmask = 16'd1 << addr[9:6];
        hit = lookup_region(rtag);
        if (hit >= 0) begin
            if (rg_tab[hit].dense) begin
                d = rg_tab[hit].dir ? 64'hFFFF_FFFF_FFFF_FFC0 : 64'h40;
                r.l1 = scale_addr(addr, d, rg_tab[hit].step, 0);
                r.l2 = scale_addr(addr, d, rg_tab[hit].step, 1);
                r.llc = scale_addr(addr, d, rg_tab[hit].step, 3);
                r.kind = KIND_STREAM;
            end
            if ((rg_tab[hit].bits & lmask) == 0) begin
                if (rg_tab[hit].cnt < CNT_MAX) rg_tab[hit].cnt++;
                if (rg_tab[hit].cnt >= dense_thr) rg_tab[hit].dense = 1'b1;
            end
            rg_tab[hit].bits |= lmask;
            rg_tab[hit].step = 2;
            rg_tab[hit].age = (rg_tab[hit].age < 2) ? 3'd0 : rg_tab[hit].age - 3'd2;
        end else begin
            ndense = 0;
            ndir = 0;
            nstep = 0;
            if (rtag < 16'hFFFF) begin
                n = lookup_region(rtag + 16'd1);
                if (n >= 0) begin
                    ndir = 1;
                    ndense = rg_tab[n].dense;
                    nstep = rg_tab[n].step;
                end
            end
            if (rtag > 0) begin
                n = lookup_region(rtag - 16'd1);
                if (n >= 0) begin
                    ndir = 0;
                    ndense = rg_tab[n].dense;
                    nstep = rg_tab[n].step;
                end
            end
            if (ndense) begin
                d = ndir ? 64'hFFFF_FFFF_FFFF_FFC0 : 64'h40;
                r.l1 = scale_addr(addr, d, nstep, 0);
                r.l2 = scale_addr(addr, d, nstep, 1);
                r.llc = scale_addr(addr, d, nstep, 3);
                r.kind = KIND_STREAM;
            end
            slot = -1;
            for (int i = 0; i < REGION_ENTRIES; i++)
                if (!rg_tab[i].valid) begin
                    slot = i;
                    break;
                end
            if (slot < 0)
                for (int i = 0; i < REGION_ENTRIES; i++)
                    if (rg_tab[i].age == AGE_MAX &&
                        (slot < 0 || rg_tab[i].tag < rg_tab[slot].tag)) slot = i;
            if (slot >= 0) begin
                rg_tab[slot] = '{valid: 1'b1, tag: rtag, cnt: 5'd1, bits: lmask, dir: ndir,
                                 dense: ndense, age: AGE_INS, step: nstep};
            end else begin
                for (int i = 0; i < REGION_ENTRIES; i++)
                    if (rg_tab[i].age < AGE_MAX) rg_tab[i].age++;
            end
        end
        r.pf_valid = r.l1 != 0;
        return r;
    endfunction

    task automatic send_item(bit op, bit [47:0] addr, bit [47:0] ip);
        int gap;
        gap = 0;
        while ($urandom_range(99, 0) < send_idle_pct && gap < 20) gap++;
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.op = op;
        in_ch.access_addr = addr;
        in_ch.instr_ptr = ip;
        do @(posedge i_clk); while (!in_ch.ready);
        if (op == OP_TICK) tick_model();
        else pf_expect_q.push_back(predict_access(addr, ip));
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid = 1'b0;
        while (pf_expect_q.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic write_threshold(bit [4:0] value);
        drain();
        cfg_ch.valid = 1'b1;
        cfg_ch.data = value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        dense_thr = value;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    always @(negedge i_clk)
        out_ch.ready = ($urandom_range(99, 0) >= recv_idle_pct);

    always @(posedge i_clk) begin
        t_prefetch exp_pf;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pf_expect_q.size() == 0) begin
                $error("prefetch result with none expected");
                err_count++;
            end else begin
                exp_pf = pf_expect_q.pop_front();
                if (out_ch.pf_kind !== exp_pf.kind) begin
                    $error("pf_kind expected %0d actual %0d", exp_pf.kind, out_ch.pf_kind);
                    err_count++;
                end
                if (out_ch.pf_valid !== exp_pf.pf_valid) begin
                    $error("pf_valid expected %0d actual %0d", exp_pf.pf_valid,
                           out_ch.pf_valid);
                    err_count++;
                end
                if (out_ch.pf_near_addr !== exp_pf.l1) begin
                    $error("pf_near_addr expected %h actual %h", exp_pf.l1,
                           out_ch.pf_near_addr);
                    err_count++;
                end
                if (out_ch.pf_mid_addr !== exp_pf.l2) begin
                    $error("pf_mid_addr expected %h actual %h", exp_pf.l2, out_ch.pf_mid_addr);
                    err_count++;
                end
                if (out_ch.pf_llc_addr !== exp_pf.llc) begin
                    $error("pf_llc_addr expected %h actual %h", exp_pf.llc,
                           out_ch.pf_llc_addr);
                    err_count++;
                end
            end
        end
    end

    task automatic test_directed();
        bit [47:0] a;
        send_item(OP_LOAD, 48'h0, 48'h0);
        send_item(OP_LOAD, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_item(OP_LOAD, 48'h0000_0000_0400, 48'h0);
        send_item(OP_LOAD, 48'hFFFF_FFFF_FBC0, 48'hFFFF_FFFF_FFFF);
        for (int i = 0; i < 5; i++) send_item(OP_LOAD, 48'h10_0000 + i * 48'h80_0000, 48'h444);
        for (int i = 0; i < 5; i++) send_item(OP_LOAD, 48'h8000 - i * 48'h40, 48'h888);
        for (int i = 0; i < 5; i++)
            send_item(OP_LOAD, 48'h2_0000_0000 + i * 48'h1_0000_0000, 48'hCCC);
        a = 48'h5000;
        for (int i = 0; i < 6; i++) begin
            a += (i % 2) ? 48'h8 : 48'h18;
            send_item(OP_LOAD, a, 48'h1230);
        end
        send_item(OP_TICK, rand48(), rand48());
    endtask

    task automatic test_idle_scaling();
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 5; i++)
                send_item(OP_LOAD, 48'h9_0000 + i * 48'h100, 48'h7770);
            repeat (k * 10 + 8) send_item(OP_TICK, rand48(), rand48());
        end
        repeat (40) send_item(OP_TICK, 48'h0, 48'h0);
        send_item(OP_LOAD, 48'h9_0600, 48'h7770);
        send_item(OP_LOAD, 48'h9_0700, 48'h7770);
    endtask

    task automatic reseed_pool(int k);
        pool_ip[k] = rand48();
        pool_addr[k] = rand48();
        pool_per[k] = $urandom_range(5, 1);
        pool_pos[k] = 0;
        for (int j = 0; j < 5; j++)
            case ($urandom_range(4, 0))
                0: pool_pat[k][j] = $urandom_range(255, 1);
                1: pool_pat[k][j] = 32'h40 * $urandom_range(4, 1);
                2: pool_pat[k][j] = -(32'h40 * $urandom_range(4, 1));
                3: pool_pat[k][j] = $urandom_range(24'hFFFFFF, 0);
                default: pool_pat[k][j] = $urandom();
            endcase
    endtask

    task automatic test_random(int count);
        int k;
        for (int k0 = 0; k0 < 12; k0++) reseed_pool(k0);
        sweep_addr = rand48();
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(11, 0);
            case ($urandom_range(19, 0))
                0, 1: send_item(OP_TICK, rand48(), rand48());
                2, 3, 4, 5, 6, 7, 8, 9, 10: begin
                    if ($urandom_range(39, 0) == 0) reseed_pool(k);
                    pool_addr[k] += 48'(signed'(pool_pat[k][pool_pos[k]]));
                    pool_pos[k] = (pool_pos[k] + 1) % pool_per[k];
                    send_item(OP_LOAD, pool_addr[k], pool_ip[k]);
                end
                11, 12, 13, 14: begin
                    if ($urandom_range(29, 0) == 0) sweep_addr = rand48();
                    sweep_addr += ($urandom_range(3, 0) == 0) ? -48'h40 : 48'h40;
                    send_item(OP_LOAD, sweep_addr, pool_ip[k % 3]);
                end
                15: send_item(OP_LOAD, 48'h0 + 48'($urandom_range(4095, 0)), rand48());
                16: send_item(OP_LOAD, 48'hFFFF_FFFF_F000 + 48'($urandom_range(4095, 0)),
                              rand48());
                default: send_item(OP_LOAD, rand48(), rand48());
            endcase
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.op = OP_LOAD;
        in_ch.access_addr = '0;
        in_ch.instr_ptr = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        reset_model();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 11;
        recv_idle_pct = 52;
        test_directed();
        test_random(620);
        write_threshold(5'd1);
        test_random(150);

        send_idle_pct = 52;
        recv_idle_pct = 11;
        write_threshold(5'd0);
        test_idle_scaling();
        test_random(300);
        write_threshold(5'd16);
        test_random(250);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_threshold(5'd31);
        test_random(200);
        write_threshold(5'($urandom_range(16, 2)));
        test_random(280);

        drain();
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
